### rtl/abb_pkg.sv
package abb_pkg;

  // canvas and source limits
  localparam int unsigned MAX_CANVAS_WIDTH  = 256;
  localparam int unsigned MAX_CANVAS_HEIGHT = 256;
  localparam int unsigned MAX_SOURCE_SIDE   = 4096;

  localparam int unsigned X_BITS       = $clog2(MAX_CANVAS_WIDTH);
  localparam int unsigned Y_BITS       = $clog2(MAX_CANVAS_HEIGHT);
  localparam int unsigned FB_DEPTH     = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
  localparam int unsigned FB_ADDR_BITS = X_BITS + Y_BITS;
  localparam int unsigned PIXEL_BITS   = 32;

  // register field widths
  localparam int unsigned CANVAS_BITS = 9;
  localparam int unsigned DEST_BITS   = 16;
  localparam int unsigned SIDE_BITS   = 13;
  localparam int unsigned COUNT_BITS  = $clog2(MAX_SOURCE_SIDE);
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] BLEND_ROUND  = 8'd127;

  typedef enum logic [1:0] {
    OP_BLIT   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_DEST_X        = 3'd2,
    REG_DEST_Y        = 3'd3,
    REG_SOURCE_WIDTH  = 3'd4,
    REG_SOURCE_HEIGHT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

endpackage

### rtl/alpha_blend_blitter.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------------
// input     | in_valid / in_stall        | operation, red, green, blue, alpha,
//           |                            | pos_x, pos_y
// result    | out_valid / out_stall      | written, out_x, out_y, out_red,
//           |                            | out_green, out_blue, out_alpha, image_done
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one item per clock sustained while in_stall is low; framebuffer read at the transfer
// edge into the blend stage, blend and write-back there, then the output register
// reset starts a clearing pass over all 65536 framebuffer words, one word per cycle;
// in_stall stays high until it ends, config writes are taken throughout
// else in_stall rises only while the blend stage holds an item behind a stalled result
module alpha_blend_blitter import abb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                operation,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic [7:0]                alpha,
  input  logic [7:0]                pos_x,
  input  logic [7:0]                pos_y,
  // results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      written,
  output logic [7:0]                out_x,
  output logic [7:0]                out_y,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  output logic                      image_done,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration registers
  logic [CANVAS_BITS-1:0] canvas_width;
  logic [CANVAS_BITS-1:0] canvas_height;
  logic [DEST_BITS-1:0]   dest_x;
  logic [DEST_BITS-1:0]   dest_y;
  logic [SIDE_BITS-1:0]   source_width;
  logic [SIDE_BITS-1:0]   source_height;

  // source position counters
  logic [COUNT_BITS-1:0] source_column;
  logic [COUNT_BITS-1:0] source_row;

  // clearing pass
  logic                    clearing;
  logic [FB_ADDR_BITS-1:0] clear_addr;

  // blend stage
  logic                    s1_valid;
  op_t                     s1_op;
  logic                    s1_hit;
  logic [FB_ADDR_BITS-1:0] s1_addr;
  logic [7:0]              s1_x;
  logic [7:0]              s1_y;
  pixel_t                  s1_src;
  logic                    s1_done;

  // last word written by an item, for read-after-write forwarding
  logic                    fwd_valid;
  logic [FB_ADDR_BITS-1:0] fwd_addr;
  pixel_t                  fwd_data;

  logic cfg_write;
  logic accept;
  logic out_free;
  logic s1_move;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  assign out_free = ~out_valid | ~out_stall;
  assign s1_move  = out_free;
  assign in_stall = clearing | (s1_valid & ~out_free);
  assign accept   = in_valid & ~in_stall;

  // ---------------------------------------------------------------------------
  // address stage: effective sizes, placement and clipping
  // ---------------------------------------------------------------------------
  logic [CANVAS_BITS-1:0] cw_eff;
  logic [CANVAS_BITS-1:0] ch_eff;
  logic [SIDE_BITS-1:0]   sw_eff;
  logic [SIDE_BITS-1:0]   sh_eff;
  logic [DEST_BITS+1:0]   blit_x;
  logic [DEST_BITS+1:0]   blit_y;
  logic                   last_col;
  logic                   last_row;
  logic                   blit_hit;
  logic                   direct_hit;
  op_t                    in_op;
  logic [7:0]             s0_x;
  logic [7:0]             s0_y;
  logic                   s0_hit;
  logic [FB_ADDR_BITS-1:0] s0_addr;

  assign in_op = op_t'(operation);

  always_comb begin
    // oversized canvas saturates; zero clips everything
    cw_eff = (canvas_width > CANVAS_BITS'(MAX_CANVAS_WIDTH))
             ? CANVAS_BITS'(MAX_CANVAS_WIDTH) : canvas_width;
    ch_eff = (canvas_height > CANVAS_BITS'(MAX_CANVAS_HEIGHT))
             ? CANVAS_BITS'(MAX_CANVAS_HEIGHT) : canvas_height;
    // zero source side counts as one, oversized saturates
    if (source_width == '0) begin
      sw_eff = SIDE_BITS'(1);
    end else if (source_width > SIDE_BITS'(MAX_SOURCE_SIDE)) begin
      sw_eff = SIDE_BITS'(MAX_SOURCE_SIDE);
    end else begin
      sw_eff = source_width;
    end
    if (source_height == '0) begin
      sh_eff = SIDE_BITS'(1);
    end else if (source_height > SIDE_BITS'(MAX_SOURCE_SIDE)) begin
      sh_eff = SIDE_BITS'(MAX_SOURCE_SIDE);
    end else begin
      sh_eff = source_height;
    end

    blit_x = {{2{dest_x[DEST_BITS-1]}}, dest_x} + (DEST_BITS+2)'(source_column);
    blit_y = {{2{dest_y[DEST_BITS-1]}}, dest_y} + (DEST_BITS+2)'(source_row);
    last_col = (SIDE_BITS'(source_column) + SIDE_BITS'(1)) >= sw_eff;
    last_row = (SIDE_BITS'(source_row) + SIDE_BITS'(1)) >= sh_eff;

    blit_hit = ~blit_x[DEST_BITS+1] & ~blit_y[DEST_BITS+1]
             & (blit_x[DEST_BITS:0] < (DEST_BITS+1)'(cw_eff))
             & (blit_y[DEST_BITS:0] < (DEST_BITS+1)'(ch_eff));
    direct_hit = (CANVAS_BITS'(pos_x) < cw_eff) & (CANVAS_BITS'(pos_y) < ch_eff);

    if (in_op == OP_BLIT) begin
      s0_x   = blit_x[7:0];
      s0_y   = blit_y[7:0];
      s0_hit = blit_hit;
    end else begin
      s0_x   = pos_x;
      s0_y   = pos_y;
      s0_hit = direct_hit;
    end
    // pixel (x, y) at y * MAX_CANVAS_WIDTH + x
    s0_addr = {s0_y[Y_BITS-1:0], s0_x[X_BITS-1:0]};
  end

  // configuration and source counters
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_BITS'(256);
      canvas_height <= CANVAS_BITS'(256);
      dest_x        <= '0;
      dest_y        <= '0;
      source_width  <= SIDE_BITS'(1);
      source_height <= SIDE_BITS'(1);
      source_column <= '0;
      source_row    <= '0;
    end else begin
      if (accept && in_op == OP_BLIT) begin
        if (last_col) begin
          source_column <= '0;
          source_row    <= last_row ? '0 : source_row + COUNT_BITS'(1);
        end else begin
          source_column <= source_column + COUNT_BITS'(1);
        end
      end
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[CANVAS_BITS-1:0];
          REG_CANVAS_HEIGHT: canvas_height <= cfg_data[CANVAS_BITS-1:0];
          REG_DEST_X:        dest_x        <= cfg_data;
          REG_DEST_Y:        dest_y        <= cfg_data;
          REG_SOURCE_WIDTH:  source_width  <= cfg_data[SIDE_BITS-1:0];
          REG_SOURCE_HEIGHT: source_height <= cfg_data[SIDE_BITS-1:0];
          default: ;
        endcase
        // placement or size change restarts the image
        if (cfg_index == REG_DEST_X || cfg_index == REG_DEST_Y ||
            cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT) begin
          source_column <= '0;
          source_row    <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // framebuffer
  // ---------------------------------------------------------------------------
  logic                    fb_wr_en;
  logic [FB_ADDR_BITS-1:0] fb_wr_addr;
  pixel_t                  fb_wr_data;
  pixel_t                  fb_rd_data;
  logic                    item_wr_en;
  pixel_t                  item_wr_data;

  abb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (FB_DEPTH)
  ) u_fb (
    .clk     (clk),
    .wr_en   (fb_wr_en),
    .wr_addr (fb_wr_addr),
    .wr_data (fb_wr_data),
    .rd_en   (accept),
    .rd_addr (s0_addr),
    .rd_data (fb_rd_data)
  );

  // the clearing pass owns the write port until it ends
  always_comb begin
    if (clearing) begin
      fb_wr_en   = 1'b1;
      fb_wr_addr = clear_addr;
      fb_wr_data = '0;
    end else begin
      fb_wr_en   = item_wr_en;
      fb_wr_addr = s1_addr;
      fb_wr_data = item_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + FB_ADDR_BITS'(1);
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // blend stage: read data, forwarding, blend, write-back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= in_op;
      s1_hit    <= s0_hit;
      s1_addr   <= s0_addr;
      s1_x      <= s0_x;
      s1_y      <= s0_y;
      s1_src    <= '{red: red, green: green, blue: blue, alpha: alpha};
      s1_done   <= (in_op == OP_BLIT) & last_col & last_row;
    end
  end

  pixel_t cur_pixel;
  pixel_t blended;
  logic   blend_write;
  logic   direct_write;

  // the word written by the previous item may not be in the read data yet
  assign cur_pixel = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : fb_rd_data;

  abb_blend u_blend (
    .src    (s1_src),
    .dst    (cur_pixel),
    .result (blended)
  );

  assign blend_write  = (s1_op == OP_BLIT) & s1_hit & (s1_src.alpha != '0);
  assign direct_write = (s1_op == OP_WRITE) & s1_hit;
  assign item_wr_en   = s1_valid & s1_move & (blend_write | direct_write);
  assign item_wr_data = direct_write ? s1_src : blended;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (item_wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_wr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= item_wr_data;
    end
  end

  // result pixel: new value when written, stored value on a transparent pixel
  // or a read, all zero when clipped or on the unused code
  pixel_t res_pixel;
  logic   res_show;

  always_comb begin
    res_show = s1_hit & (s1_op != OP_UNUSED);
    if (!res_show) begin
      res_pixel = '0;
    end else if (blend_write || direct_write) begin
      res_pixel = item_wr_data;
    end else begin
      res_pixel = cur_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      written    <= blend_write | direct_write;
      out_x      <= res_show ? s1_x : '0;
      out_y      <= res_show ? s1_y : '0;
      out_red    <= res_pixel.red;
      out_green  <= res_pixel.green;
      out_blue   <= res_pixel.blue;
      out_alpha  <= res_pixel.alpha;
      image_done <= s1_done;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item_wr_en)
    else $error("item write during clearing pass");

  a_fwd_empty_after_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> !fwd_valid && !s1_valid)
    else $error("item activity before clearing pass ended");

  a_image_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && in_op == OP_BLIT && last_col && last_row && !cfg_write
    |=> source_column == '0 && source_row == '0)
    else $error("source counters did not wrap after last pixel");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_addr) && $stable(s1_src))
    else $error("blend stage lost its item while held");

endmodule

### rtl/abb_ram.sv
module abb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/abb_blend.sv
module abb_blend import abb_pkg::*; (
  input  pixel_t src,
  input  pixel_t dst,
  output pixel_t result
);

  // (s*a + d*(255-a) + 127) / 255, the divide done as (v + 1 + (v >> 8)) >> 8,
  // exact while the quotient stays below 256
  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [16:0] v;
    logic [16:0] q;
    begin
      v = 17'(s * a) + 17'(d * (ALPHA_OPAQUE - a)) + 17'(BLEND_ROUND);
      q = v + 17'd1 + 17'(v[16:8]);
      mix = q[15:8];
    end
  endfunction

  always_comb begin
    result.red   = mix(src.red,   dst.red,   src.alpha);
    result.green = mix(src.green, dst.green, src.alpha);
    result.blue  = mix(src.blue,  dst.blue,  src.alpha);
    result.alpha = ALPHA_OPAQUE;
  end

endmodule

### tb/sv/testbench.sv
module testbench;
  import abb_pkg::*;

  // how the result side pushes back
  typedef enum {RX_READY, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // one input item and one result, laid out like the ports
  typedef struct packed {
    op_t        op;
    pixel_t     px;
    logic [7:0] x;
    logic [7:0] y;
  } pixel_op_t;

  typedef struct packed {
    logic       written;
    logic [7:0] x;
    logic [7:0] y;
    pixel_t     px;
    logic       done;
  } pixel_result_t;

  // the clearing pass alone writes all 65536 framebuffer words
  localparam int RUN_LIMIT    = 4_000_000;
  localparam int RANDOM_ITEMS = 1200;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [1:0]                operation = OP_READ;
  logic [7:0]                red       = '0;
  logic [7:0]                green     = '0;
  logic [7:0]                blue      = '0;
  logic [7:0]                alpha     = '0;
  logic [7:0]                pos_x     = '0;
  logic [7:0]                pos_y     = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      written;
  logic [7:0]                out_x;
  logic [7:0]                out_y;
  logic [7:0]                out_red;
  logic [7:0]                out_green;
  logic [7:0]                out_blue;
  logic [7:0]                out_alpha;
  logic                      image_done;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CANVAS_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  alpha_blend_blitter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .written    (written),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .image_done (image_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow framebuffer, 2-state so it starts cleared like the block after reset
  bit [31:0]          fb_shadow [FB_DEPTH];
  // shadow registers and source position counters
  logic [8:0]         canvas_w = 9'd256;
  logic [8:0]         canvas_h = 9'd256;
  logic signed [15:0] origin_x = '0;
  logic signed [15:0] origin_y = '0;
  logic [12:0]        image_w  = 13'd1;
  logic [12:0]        image_h  = 13'd1;
  int                 src_col  = 0;
  int                 src_row  = 0;

  // results still owed by the block, oldest first
  pixel_result_t pending_results [$];

  // sender and receiver pacing
  bit       tx_bursty    = 1'b0;
  int       burst_left   = 0;
  rx_mode_t rx_mode      = RX_READY;
  int       hold_request = 0;
  int       hold_left    = 0;
  int       stall_run    = 0;
  bit       stall_now    = 1'b0;

  // bookkeeping
  int n_sent       = 0;
  int n_op [4]     = '{0, 0, 0, 0};
  int n_images     = 0;
  int n_cfg_writes = 0;
  int n_checked    = 0;
  int n_mismatch   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // rounded blend of one channel: (s*a + d*(255-a) + 127) / 255
  function automatic logic [7:0] mix_channel(int s, int d, int a);
    return 8'((s * a + d * (int'(ALPHA_OPAQUE) - a) + int'(BLEND_ROUND)) / int'(ALPHA_OPAQUE));
  endfunction

  // expected result of one accepted item; updates the shadow state
  function automatic pixel_result_t predict_result(pixel_op_t item);
    pixel_result_t r;
    pixel_t        cur;
    int            vis_w, vis_h, img_w, img_h, cx, cy;
    bit            last_col, last_row;
    r = '0;
    // canvas sizes above the maximum saturate, zero clips everything
    vis_w = (canvas_w > MAX_CANVAS_WIDTH) ? MAX_CANVAS_WIDTH : int'(canvas_w);
    vis_h = (canvas_h > MAX_CANVAS_HEIGHT) ? MAX_CANVAS_HEIGHT : int'(canvas_h);
    case (item.op)
      OP_BLIT: begin
        // a zero source side counts as one, oversize saturates
        img_w = (image_w == 0) ? 1 :
                (image_w > MAX_SOURCE_SIDE) ? MAX_SOURCE_SIDE : int'(image_w);
        img_h = (image_h == 0) ? 1 :
                (image_h > MAX_SOURCE_SIDE) ? MAX_SOURCE_SIDE : int'(image_h);
        cx = int'(origin_x) + src_col;
        cy = int'(origin_y) + src_row;
        last_col = (src_col + 1 >= img_w);
        last_row = (src_row + 1 >= img_h);
        if (cx >= 0 && cy >= 0 && cx < vis_w && cy < vis_h) begin
          cur = fb_shadow[cy * MAX_CANVAS_WIDTH + cx];
          // transparent source leaves the stored pixel alone
          if (item.px.alpha != 0) begin
            cur.red   = mix_channel(item.px.red, cur.red, item.px.alpha);
            cur.green = mix_channel(item.px.green, cur.green, item.px.alpha);
            cur.blue  = mix_channel(item.px.blue, cur.blue, item.px.alpha);
            cur.alpha = ALPHA_OPAQUE;
            fb_shadow[cy * MAX_CANVAS_WIDTH + cx] = cur;
            r.written = 1'b1;
          end
          r.x  = cx[7:0];
          r.y  = cy[7:0];
          r.px = cur;
        end
        // clipped pixels still advance the walk and can end the image
        r.done = last_col && last_row;
        if (r.done) n_images++;
        if (last_col) begin
          src_col = 0;
          src_row = last_row ? 0 : src_row + 1;
        end else begin
          src_col++;
        end
      end
      OP_WRITE: begin
        if (item.x < vis_w && item.y < vis_h) begin
          fb_shadow[{item.y, item.x}] = item.px;
          r.written = 1'b1;
          r.x       = item.x;
          r.y       = item.y;
          r.px      = item.px;
        end
      end
      OP_READ: begin
        if (item.x < vis_w && item.y < vis_h) begin
          r.x  = item.x;
          r.y  = item.y;
          r.px = fb_shadow[{item.y, item.x}];
        end
      end
      default: ;  // unused code: all zero, nothing changes
    endcase
    return r;
  endfunction

  function automatic pixel_op_t make_item(op_t op, logic [31:0] rgba,
                                          logic [7:0] x, logic [7:0] y);
    return {op, rgba, x, y};
  endfunction

  // random content; alpha leans toward transparent and opaque, and half the
  // reads and writes land around the current image so blends get read back
  function automatic pixel_op_t random_item(op_t op);
    logic [31:0] rgba;
    logic [7:0]  x, y;
    rgba = $urandom;
    case ($urandom_range(0, 4))
      0:       rgba[7:0] = 8'h00;
      1:       rgba[7:0] = ALPHA_OPAQUE;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      x = 8'(int'(origin_x) + int'($urandom_range(0, 13)) - 1);
      y = 8'(int'(origin_y) + int'($urandom_range(0, 7)) - 1);
    end else begin
      x = 8'($urandom);
      y = 8'($urandom);
    end
    return make_item(op, rgba, x, y);
  endfunction

  // one input transfer; entered and left at a falling edge, valid stays high
  // unless the burst ends here
  task automatic send_item(input pixel_op_t item);
    in_valid  <= 1'b1;
    operation <= item.op;
    red       <= item.px.red;
    green     <= item.px.green;
    blue      <= item.px.blue;
    alpha     <= item.px.alpha;
    pos_x     <= item.x;
    pos_y     <= item.y;
    do @(posedge clk); while (in_stall);
    // transfer taken at this edge
    pending_results.push_back(predict_result(item));
    n_sent++;
    n_op[item.op]++;
    @(negedge clk);
    if (tx_bursty) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        // gap with junk on the payload, which must be ignored
        in_valid  <= 1'b0;
        operation <= 2'($urandom);
        red       <= 8'($urandom);
        green     <= 8'($urandom);
        blue      <= 8'($urandom);
        alpha     <= 8'($urandom);
        pos_x     <= 8'($urandom);
        pos_y     <= 8'($urandom);
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5))
          @(negedge clk);
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  // sender pauses until every owed result is back; the block is idle after
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CANVAS_WIDTH:  canvas_w = data[8:0];
      REG_CANVAS_HEIGHT: canvas_h = data[8:0];
      REG_DEST_X:        origin_x = data;
      REG_DEST_Y:        origin_y = data;
      REG_SOURCE_WIDTH:  image_w  = data[12:0];
      REG_SOURCE_HEIGHT: image_h  = data[12:0];
      default: ;
    endcase
    // placement or size change restarts the image walk
    if (idx >= REG_DEST_X) begin
      src_col = 0;
      src_row = 0;
    end
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: stall runs of random length, or a long counted hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          case (rx_mode)
            RX_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
            RX_HEAVY: stall_now = ($urandom_range(0, 2) != 0);
            default:  stall_now = 1'b0;
          endcase
          stall_run = $urandom_range(1, 8);
        end
        stall_run--;
        out_stall <= stall_now;
      end
    end
  end

  // compare every result transfer with the oldest owed result
  always @(posedge clk) begin
    pixel_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {written, out_x, out_y, out_red, out_green, out_blue, out_alpha, image_done};
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: wr=%0b x=%0d y=%0d px=%08h done=%0b",
                   got.written, got.x, got.y, got.px, got.done);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result %0d: expected wr=%0b x=%0d y=%0d px=%08h done=%0b, %s%0b %0d %0d %08h %0b",
                     n_checked, want.written, want.x, want.y, want.px, want.done,
                     "got ", got.written, got.x, got.y, got.px, got.done);
        end
      end
    end
  end

  // cleared canvas reads back zero at the corners; unused code gives all zero
  task automatic test_cleared_canvas();
    send_item(make_item(OP_READ, 32'h0, 8'd0, 8'd0));
    send_item(make_item(OP_READ, 32'h0, 8'd255, 8'd255));
    send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    wait_for_results();
  endtask

  // direct writes and reads against canvas edges, zero and oversize canvas
  task automatic test_direct_access();
    write_reg(REG_CANVAS_WIDTH, 16'd5);
    write_reg(REG_CANVAS_HEIGHT, 16'd3);
    send_item(make_item(OP_WRITE, 32'hFFFF_FFFF, 8'd4, 8'd2));
    send_item(make_item(OP_WRITE, 32'h1234_5678, 8'd5, 8'd0));   // past last column
    send_item(make_item(OP_WRITE, 32'h8765_4321, 8'd0, 8'd3));   // past last row
    send_item(make_item(OP_WRITE, 32'h0000_0000, 8'd0, 8'd0));
    send_item(make_item(OP_READ, 32'h0, 8'd4, 8'd2));
    send_item(make_item(OP_READ, 32'h0, 8'd5, 8'd2));
    wait_for_results();
    // zero width clips everything
    write_reg(REG_CANVAS_WIDTH, 16'd0);
    send_item(make_item(OP_WRITE, 32'hA5A5_A5A5, 8'd0, 8'd0));
    send_item(make_item(OP_READ, 32'h0, 8'd0, 8'd0));
    wait_for_results();
    // oversize saturates to the full canvas
    write_reg(REG_CANVAS_WIDTH, 16'd511);
    write_reg(REG_CANVAS_HEIGHT, 16'd511);
    send_item(make_item(OP_WRITE, 32'h8040_2001, 8'd255, 8'd255));
    send_item(make_item(OP_READ, 32'h0, 8'd255, 8'd255));
    wait_for_results();
  endtask

  // 3x3 image hanging off the top-left corner: clipped, opaque, transparent
  // and partial pixels; then zero-sized images over a stored pixel
  task automatic test_blit_clipping();
    write_reg(REG_DEST_X, 16'hFFFF);
    write_reg(REG_DEST_Y, 16'hFFFF);
    write_reg(REG_SOURCE_WIDTH, 16'd3);
    write_reg(REG_SOURCE_HEIGHT, 16'd3);
    send_item(make_item(OP_BLIT, 32'h1122_33FF, 8'($urandom), 8'($urandom)));
    send_item(make_item(OP_BLIT, 32'h4455_6601, 8'($urandom), 8'($urandom)));
    send_item(make_item(OP_BLIT, 32'h7788_9900, 8'($urandom), 8'($urandom)));
    send_item(make_item(OP_BLIT, 32'hAABB_CC80, 8'($urandom), 8'($urandom)));
    // opaque at origin
    send_item(make_item(OP_BLIT, 32'hC0FF_EEFF, 8'($urandom), 8'($urandom)));
    // transparent
    send_item(make_item(OP_BLIT, 32'hDEAD_BE00, 8'($urandom), 8'($urandom)));
    send_item(make_item(OP_BLIT, 32'h0102_0380, 8'($urandom), 8'($urandom)));
    send_item(make_item(OP_BLIT, 32'hFFFF_FF01, 8'($urandom), 8'($urandom)));
    // ends the image
    send_item(make_item(OP_BLIT, 32'h00FF_0080, 8'($urandom), 8'($urandom)));
    wait_for_results();
    write_reg(REG_SOURCE_WIDTH, 16'd0);
    write_reg(REG_SOURCE_HEIGHT, 16'd0);
    write_reg(REG_DEST_X, 16'd255);
    write_reg(REG_DEST_Y, 16'd255);
    send_item(make_item(OP_BLIT, 32'hFF00_FF01, 8'($urandom), 8'($urandom)));
    send_item(make_item(OP_BLIT, 32'h00FF_0080, 8'($urandom), 8'($urandom)));
    wait_for_results();
  endtask

  // long hold-off on results while blits keep coming, so the input stalls
  task automatic test_result_backpressure();
    write_reg(REG_DEST_X, 16'd10);
    write_reg(REG_DEST_Y, 16'd20);
    write_reg(REG_SOURCE_WIDTH, 16'd8);
    write_reg(REG_SOURCE_HEIGHT, 16'd4);
    rx_mode      = RX_READY;
    tx_bursty    = 1'b0;
    hold_request = 300;
    repeat (40) send_item(random_item(OP_BLIT));
    wait_for_results();
  endtask

  // phases of random settings, each followed by mostly whole images with
  // random direct writes, reads and unused codes mixed in
  task automatic test_random_traffic(int n_items);
    int          stop_at, phase_items, pick;
    logic [15:0] v;
    op_t         op;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      wait_for_results();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       v = 16'd0;
          1:       v = 16'($urandom_range(257, 511));
          2:       v = 16'd256;
          default: v = 16'($urandom_range(1, 256));
        endcase
        write_reg(REG_CANVAS_WIDTH, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       v = 16'd0;
          1:       v = 16'($urandom_range(257, 511));
          2:       v = 16'd256;
          default: v = 16'($urandom_range(1, 256));
        endcase
        write_reg(REG_CANVAS_HEIGHT, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'($urandom);
          3:       v = 16'($urandom_range(0, 270) - 8);
          default: v = 16'($urandom_range(0, 40) - 8);
        endcase
        write_reg(REG_DEST_X, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'($urandom);
          3:       v = 16'($urandom_range(0, 270) - 8);
          default: v = 16'($urandom_range(0, 40) - 8);
        endcase
        write_reg(REG_DEST_Y, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       v = 16'd0;
          1:       v = 16'd4096;
          2:       v = 16'd8191;
          3:       v = 16'($urandom_range(4097, 8191));
          default: v = 16'($urandom_range(1, 12));
        endcase
        write_reg(REG_SOURCE_WIDTH, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       v = 16'd0;
          1:       v = 16'd8191;
          default: v = 16'($urandom_range(1, 6));
        endcase
        write_reg(REG_SOURCE_HEIGHT, v);
      end
      rx_mode     = rx_mode_t'($urandom_range(0, 2));
      tx_bursty   = ($urandom_range(0, 2) != 0);
      burst_left  = $urandom_range(1, 20);
      phase_items = $urandom_range(20, 80);
      repeat (phase_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      op = OP_BLIT;
        else if (pick < 84) op = OP_WRITE;
        else if (pick < 96) op = OP_READ;
        else                op = OP_UNUSED;
        send_item(random_item(op));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    // the first transfer waits out the clearing pass on in_stall
    test_cleared_canvas();
    test_direct_access();
    test_blit_clipping();
    test_result_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_results();
    // let any stray result show up
    repeat (20) @(negedge clk);
    $display("%0d items (%0d blit, %0d write, %0d read, %0d unused), %0d images ended",
             n_sent, n_op[OP_BLIT], n_op[OP_WRITE], n_op[OP_READ], n_op[OP_UNUSED],
             n_images);
    $display("%0d results checked over %0d register writes, %0d mismatches",
             n_checked, n_cfg_writes, n_mismatch);
    if (n_mismatch == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
